>>> rtl/mh_pkg.sv
// Shared types, constants and the arctangent table for the heading pipeline.
`timescale 1ns / 1ps

package mh_pkg;

	localparam int SCALE_BITS = 30;
	localparam int XW         = SCALE_BITS + 3;
	localparam int ZW         = 26;
	localparam int AW         = 16;
	localparam int SW         = 17;
	localparam int CW         = 15;
	localparam int IW         = 2;
	localparam int ATAN_LEN   = 24;

	localparam logic signed [ZW-1:0] ANG_90    = 26'sd5898240;
	localparam logic signed [ZW-1:0] ROUND_BIAS = 26'sd512;
	localparam int                   ROUND_SHIFT = 10;
	localparam logic signed [SW-1:0] TWO_TURNS = 17'sd46080;
	localparam logic [AW-1:0]        FULL_TURN = 16'd23040;

	localparam logic [IW-1:0] REG_DECLINATION = 2'd0;
	localparam logic [IW-1:0] REG_MOUNT       = 2'd1;

	localparam logic signed [CW-1:0] DECLINATION_RST = 15'sd128;
	localparam logic signed [CW-1:0] MOUNT_RST       = -15'sd5760;

	typedef struct packed {
		logic valid;
		logic zero;
	} mh_ctl_t;

	// atan(2^-i) in degrees times 65536
	function automatic logic signed [ZW-1:0] atan_val(input int unsigned i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 26'sd2949120;
			1: v = 26'sd1740967;
			2: v = 26'sd919879;
			3: v = 26'sd466945;
			4: v = 26'sd234379;
			5: v = 26'sd117304;
			6: v = 26'sd58666;
			7: v = 26'sd29335;
			8: v = 26'sd14668;
			9: v = 26'sd7334;
			10: v = 26'sd3667;
			11: v = 26'sd1833;
			12: v = 26'sd917;
			13: v = 26'sd458;
			14: v = 26'sd229;
			15: v = 26'sd115;
			16: v = 26'sd57;
			17: v = 26'sd29;
			18: v = 26'sd14;
			19: v = 26'sd7;
			20: v = 26'sd4;
			21: v = 26'sd2;
			22: v = 26'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/mh_prerot.sv
// Input stage: scales the sample and folds the left half plane into the right.
`timescale 1ns / 1ps

module mh_prerot #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic signed [SAMPLE_BITS-1:0]       mag_x,
	input  logic signed [SAMPLE_BITS-1:0]       mag_y,
	output logic signed [mh_pkg::XW-1:0]        res_x,
	output logic signed [mh_pkg::XW-1:0]        res_y,
	output logic signed [mh_pkg::ZW-1:0]        res_z,
	output mh_pkg::mh_ctl_t                     res_ctl
);

	localparam int XW    = mh_pkg::XW;
	localparam int ZW    = mh_pkg::ZW;
	localparam int SHIFT = mh_pkg::SCALE_BITS - SAMPLE_BITS;

	logic signed [XW-1:0] sx, sy, nx, ny;
	logic signed [ZW-1:0] nz;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	mh_pkg::mh_ctl_t      ctl_s1;

	assign sx = XW'(mag_x) <<< SHIFT;
	assign sy = XW'(mag_y) <<< SHIFT;

	always_comb begin
		nx = sx;
		ny = sy;
		nz = '0;
		if (sx < 0) begin
			if (sy >= 0) begin
				nx = sy;
				ny = -sx;
				nz = mh_pkg::ANG_90;
			end else begin
				nx = -sy;
				ny = sx;
				nz = -mh_pkg::ANG_90;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= load;
			ctl_s1.zero  <= (mag_x == '0) && (mag_y == '0);
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= nx;
		y_s1 <= ny;
		z_s1 <= nz;
	end

	assign res_x   = x_s1;
	assign res_y   = y_s1;
	assign res_z   = z_s1;
	assign res_ctl = ctl_s1;

endmodule

>>> rtl/mh_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation.
`timescale 1ns / 1ps

module mh_cordic_stage #(
	parameter int STAGE = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [mh_pkg::XW-1:0] src_x,
	input  logic signed [mh_pkg::XW-1:0] src_y,
	input  logic signed [mh_pkg::ZW-1:0] src_z,
	input  mh_pkg::mh_ctl_t              src_ctl,
	output logic signed [mh_pkg::XW-1:0] res_x,
	output logic signed [mh_pkg::XW-1:0] res_y,
	output logic signed [mh_pkg::ZW-1:0] res_z,
	output mh_pkg::mh_ctl_t              res_ctl
);

	localparam int XW = mh_pkg::XW;
	localparam int ZW = mh_pkg::ZW;
	localparam logic signed [ZW-1:0] ATAN = mh_pkg::atan_val(STAGE);

	logic signed [XW-1:0] dx, dy;
	logic                 up;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	mh_pkg::mh_ctl_t      ctl_s1;

	assign dx = src_y >>> STAGE;
	assign dy = src_x >>> STAGE;
	assign up = !src_y[XW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= src_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (up) begin
			x_s1 <= src_x + dx;
			y_s1 <= src_y - dy;
			z_s1 <= src_z + ATAN;
		end else begin
			x_s1 <= src_x - dx;
			y_s1 <= src_y + dy;
			z_s1 <= src_z - ATAN;
		end
	end

	assign res_x   = x_s1;
	assign res_y   = y_s1;
	assign res_z   = z_s1;
	assign res_ctl = ctl_s1;

endmodule

>>> rtl/mh_wrap.sv
// Output stages: rounds the angle, adds both offsets and wraps into one turn.
`timescale 1ns / 1ps

module mh_wrap (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [mh_pkg::ZW-1:0] src_z,
	input  mh_pkg::mh_ctl_t              src_ctl,
	input  logic signed [mh_pkg::CW-1:0] declination,
	input  logic signed [mh_pkg::CW-1:0] mount_offset,
	output logic                         done,
	output logic [mh_pkg::CW-1:0]        heading_deg
);

	localparam int ZW = mh_pkg::ZW;
	localparam int AW = mh_pkg::AW;
	localparam int SW = mh_pkg::SW;
	localparam int CW = mh_pkg::CW;

	logic signed [ZW-1:0] zr;
	logic signed [AW-1:0] ang;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] sum_s1;
	logic                 valid_s1;
	logic [AW-1:0]        val_s2;
	logic                 valid_s2;
	logic [CW-1:0]        heading_s3;
	logic                 valid_s3;
	logic signed [SW-1:0] lifted;

	assign zr  = src_z + mh_pkg::ROUND_BIAS;
	assign ang = src_ctl.zero ? '0 : AW'(zr >>> mh_pkg::ROUND_SHIFT);
	assign sum = SW'(ang) + SW'(declination) + SW'(mount_offset);

	assign lifted = sum_s1[SW-1] ? (sum_s1 + mh_pkg::TWO_TURNS) : sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= src_ctl.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= sum;
		val_s2 <= lifted[AW-1:0];
		if (val_s2 >= mh_pkg::FULL_TURN) begin
			heading_s3 <= CW'(val_s2 - mh_pkg::FULL_TURN);
		end else begin
			heading_s3 <= val_s2[CW-1:0];
		end
	end

	assign done        = valid_s3;
	assign heading_deg = heading_s3;

endmodule

>>> rtl/magnetometer_heading.sv
// Top level: compass heading from one magnetometer sample, CORDIC pipeline.
//
//  channel   direction  handshake                 payload
//  command   in         start, busy               mag_x, mag_y
//  result    out        done (one-cycle strobe)   heading_deg
//  config    in         cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One sample is taken every cycle; busy stays low and cfg_ready stays high.
// From the start transfer to done a sample passes one input stage, one stage per
// micro-rotation, then round/offset, lift and wrap stages.
// Reset clears every valid bit and loads declination 128 and mount offset -5760.
// The pipeline never stalls; the receiver takes each result in its done cycle.
`timescale 1ns / 1ps

module magnetometer_heading #(
	parameter int SAMPLE_BITS   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] mag_x,
	input  logic signed [SAMPLE_BITS-1:0] mag_y,
	output logic                          done,
	output logic [mh_pkg::CW-1:0]         heading_deg,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mh_pkg::IW-1:0]         cfg_index,
	input  logic [mh_pkg::CW-1:0]         cfg_data
);

	localparam int XW = mh_pkg::XW;
	localparam int ZW = mh_pkg::ZW;
	localparam int CW = mh_pkg::CW;

	logic signed [XW-1:0] xs   [0:CORDIC_STAGES];
	logic signed [XW-1:0] ys   [0:CORDIC_STAGES];
	logic signed [ZW-1:0] zs   [0:CORDIC_STAGES];
	mh_pkg::mh_ctl_t      ctls [0:CORDIC_STAGES];

	logic signed [CW-1:0] decl_q;
	logic signed [CW-1:0] mount_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q  <= mh_pkg::DECLINATION_RST;
			mount_q <= mh_pkg::MOUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mh_pkg::REG_DECLINATION: decl_q  <= cfg_data;
				mh_pkg::REG_MOUNT:       mount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mh_prerot #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_prerot (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (start && !busy),
		.mag_x   (mag_x),
		.mag_y   (mag_y),
		.res_x   (xs[0]),
		.res_y   (ys[0]),
		.res_z   (zs[0]),
		.res_ctl (ctls[0])
	);

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		mh_cordic_stage #(
			.STAGE(k)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.src_x   (xs[k]),
			.src_y   (ys[k]),
			.src_z   (zs[k]),
			.src_ctl (ctls[k]),
			.res_x   (xs[k+1]),
			.res_y   (ys[k+1]),
			.res_z   (zs[k+1]),
			.res_ctl (ctls[k+1])
		);
	end

	mh_wrap u_wrap (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_z        (zs[CORDIC_STAGES]),
		.src_ctl      (ctls[CORDIC_STAGES]),
		.declination  (decl_q),
		.mount_offset (mount_q),
		.done         (done),
		.heading_deg  (heading_deg)
	);

endmodule

>>> rtl/mh_chk.sv
// Port-level checks on latency and result range, bound to the top level.
`timescale 1ns / 1ps

module mh_chk #(
	parameter int CORDIC_STAGES = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [mh_pkg::CW-1:0] heading_deg
);

	localparam int LAT = CORDIC_STAGES + 4;
	localparam logic [mh_pkg::CW-1:0] MAX_HEADING = 15'd23039;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("transfer accepted but no result after pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching command transfer");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (heading_deg <= MAX_HEADING))
		else $error("heading outside one full turn");

endmodule

bind magnetometer_heading mh_chk #(
	.CORDIC_STAGES(CORDIC_STAGES)
) u_mh_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.heading_deg (heading_deg)
);

>>> test/tb_top.sv
// Testbench for the magnetometer heading pipeline: predicted headings checked against every result.
`timescale 1ns / 1ps

module tb_top;

	localparam int  SAMPLE_BITS = 16;
	localparam int  STAGES      = 16;
	localparam int  LATENCY     = STAGES + 4;
	localparam int  LIMIT       = 200000;
	localparam int  TURN        = 23040;
	localparam int  PHASES      = 6;
	localparam int  PHASE_ITEMS = 210;
	localparam logic [mh_pkg::IW-1:0] REG_SPARE_A = 2'd2;
	localparam logic [mh_pkg::IW-1:0] REG_SPARE_B = 2'd3;

	class heading_board;
		longint                        atan_deg16[24];
		logic signed [mh_pkg::CW-1:0]  declination;
		logic signed [mh_pkg::CW-1:0]  mount_offset;
		logic [mh_pkg::CW-1:0]         expected_heading[$];
		int                            mismatch_count;

		function new();
			atan_deg16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
				14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
			declination    = mh_pkg::DECLINATION_RST;
			mount_offset   = mh_pkg::MOUNT_RST;
			mismatch_count = 0;
		endfunction

		function void set_reg(logic [mh_pkg::IW-1:0] idx, logic [mh_pkg::CW-1:0] data);
			case (idx)
				mh_pkg::REG_DECLINATION: declination = data;
				mh_pkg::REG_MOUNT:       mount_offset = data;
				default: ;
			endcase
		endfunction

		function logic [mh_pkg::CW-1:0] predict_heading(logic signed [SAMPLE_BITS-1:0] mx,
				logic signed [SAMPLE_BITS-1:0] my);
			longint x;
			longint y;
			longint z;
			longint t;
			longint dx;
			longint dy;
			longint h;
			x = longint'(mx) * (longint'(1) << (30 - SAMPLE_BITS));
			y = longint'(my) * (longint'(1) << (30 - SAMPLE_BITS));
			z = 0;
			if (x != 0 || y != 0) begin
				// rotate into the right half plane
				if (x < 0) begin
					if (y >= 0) begin
						t = x; x = y; y = -t; z = 5898240;
					end else begin
						t = x; x = -y; y = t; z = -5898240;
					end
				end
				for (int i = 0; i < STAGES; i++) begin
					dx = y >>> i;
					dy = x >>> i;
					if (y >= 0) begin
						x = x + dx; y = y - dy; z = z + atan_deg16[i];
					end else begin
						x = x - dx; y = y + dy; z = z - atan_deg16[i];
					end
				end
				z = (z + 512) >>> 10;
			end
			h = z + longint'(declination) + longint'(mount_offset);
			h = h % TURN;
			if (h < 0)
				h = h + TURN;
			return h[mh_pkg::CW-1:0];
		endfunction

		function void note_sample(logic signed [SAMPLE_BITS-1:0] mx,
				logic signed [SAMPLE_BITS-1:0] my);
			expected_heading.push_back(predict_heading(mx, my));
		endfunction

		function void check_heading(logic [mh_pkg::CW-1:0] actual);
			logic [mh_pkg::CW-1:0] want;
			if (expected_heading.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected heading %0d with nothing pending", actual);
			end else begin
				want = expected_heading.pop_front();
				if (actual !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("heading_deg expected %0d actual %0d", want, actual);
				end
			end
		endfunction

		function int pending();
			return expected_heading.size();
		endfunction

		function int mismatches();
			return mismatch_count;
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic signed [SAMPLE_BITS-1:0] mag_x;
	logic signed [SAMPLE_BITS-1:0] mag_y;
	logic                          done;
	logic [mh_pkg::CW-1:0]         heading_deg;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [mh_pkg::IW-1:0]         cfg_index;
	logic [mh_pkg::CW-1:0]         cfg_data;

	heading_board board = new();
	bit           idle_off;
	int           cycle_count;

	magnetometer_heading #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.CORDIC_STAGES(STAGES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mag_x      (mag_x),
		.mag_y      (mag_y),
		.done       (done),
		.heading_deg(heading_deg),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_heading(heading_deg);
			if (start && !busy)
				board.note_sample(mag_x, mag_y);
			if (cfg_valid && cfg_ready)
				board.set_reg(cfg_index, cfg_data);
		end
	end

	task automatic send_sample(logic signed [SAMPLE_BITS-1:0] x, logic signed [SAMPLE_BITS-1:0] y);
		while (!idle_off && $urandom_range(99) < 17) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		mag_x <= x;
		mag_y <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [mh_pkg::IW-1:0] idx, logic [mh_pkg::CW-1:0] data);
		while (!idle_off && $urandom_range(99) < 17) begin
			cfg_valid <= 1'b0;
			@(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		while (board.pending() != 0)
			@(negedge clk);
		repeat (LATENCY + 4)
			@(negedge clk);
	endtask

	task automatic directed_pass();
		int dir_x[22] = '{0, 1, 0, -1, 0, -1, -1, 1, 1, 32767, -32768, 0, 0,
			32767, -32768, -32768, 32767, -32768, 32767, -32767, -32768, 32767};
		int dir_y[22] = '{0, 0, 1, 0, -1, -1, 1, -1, 1, 0, 0, 32767, -32768,
			32767, -32768, 32767, -32768, -1, 1, 0, 1, -1};
		for (int i = 0; i < 22; i++)
			send_sample(SAMPLE_BITS'(dir_x[i]), SAMPLE_BITS'(dir_y[i]));
	endtask

	task automatic random_sample(output logic signed [SAMPLE_BITS-1:0] x,
			output logic signed [SAMPLE_BITS-1:0] y);
		int edges[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			x = SAMPLE_BITS'($urandom);
			y = SAMPLE_BITS'($urandom);
		end else if (r < 75) begin
			x = SAMPLE_BITS'(int'($urandom_range(8)) - 4);
			y = SAMPLE_BITS'(int'($urandom_range(8)) - 4);
		end else if (r < 85) begin
			x = SAMPLE_BITS'($urandom);
			y = '0;
			if ($urandom_range(1)) begin
				y = x;
				x = '0;
			end
		end else begin
			x = SAMPLE_BITS'(edges[$urandom_range(6)]);
			y = SAMPLE_BITS'(edges[$urandom_range(6)]);
		end
	endtask

	initial begin
		logic signed [SAMPLE_BITS-1:0] sx;
		logic signed [SAMPLE_BITS-1:0] sy;
		int                            decl;
		int                            mount;
		arst_n      = 1'b0;
		start       = 1'b0;
		mag_x       = '0;
		mag_y       = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		idle_off    = 1'b0;
		cycle_count = 0;
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_pass();
		start <= 1'b0;
		drain();
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin decl = 11520;  mount = 11520;  end
				1: begin decl = -11520; mount = -11520; end
				2: begin decl = 16383;  mount = -16384; end
				3: begin decl = 0;      mount = 0;      end
				4: begin
					decl  = int'($urandom_range(23040)) - 11520;
					mount = int'($urandom_range(23040)) - 11520;
				end
				default: begin
					decl  = $urandom;
					mount = $urandom;
				end
			endcase
			write_reg(REG_SPARE_A, mh_pkg::CW'($urandom));
			write_reg(mh_pkg::REG_DECLINATION, mh_pkg::CW'(decl));
			write_reg(REG_SPARE_B, mh_pkg::CW'($urandom));
			write_reg(mh_pkg::REG_MOUNT, mh_pkg::CW'(mount));
			cfg_valid <= 1'b0;
			// full-turn wrap: zero angle plus both offsets at a half turn each
			if (phase == 0)
				directed_pass();
			idle_off = (phase == 3);
			repeat (PHASE_ITEMS) begin
				random_sample(sx, sy);
				send_sample(sx, sy);
			end
			idle_off = 1'b0;
			start <= 1'b0;
			drain();
		end
		if (board.mismatches() == 0 && board.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
